FILE: design/swmq_pkg.sv
// ----------------------------------------------------------------------------
// swmq_pkg
// Shared constants, codes and types of the square window max query block.
// ----------------------------------------------------------------------------
package swmq_pkg;

    // Store geometry
    localparam int MAX_DIM     = 512;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int SIZE_W      = DIM_W + 1;
    localparam int LEVELS      = 10;
    localparam int LEV_W       = $clog2(LEVELS + 1);
    localparam int LOG_W       = $clog2(SIZE_W + 1);
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = LEV_W + 2 * DIM_W;
    localparam int DEPTH       = LEVELS * MAX_DIM * MAX_DIM;

    // Field widths of the stream payload
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SIDE_W   = 10;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_ANSWER = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BUILT  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE  = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Memory port request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_value            wdata;
    } t_mem_req;

    // Floor of log2 for a nonzero side length
    function automatic logic [LOG_W-1:0] f_log2(input logic [SIDE_W-1:0] v);
        logic [LOG_W-1:0] res;
        res = '0;
        for (int i = 0; i < SIDE_W; i++) begin
            if (v[i]) begin
                res = LOG_W'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: design/swmq_mem.sv
// ----------------------------------------------------------------------------
// swmq_mem
// Single-port store of all sparse table levels, registered read data.
// ----------------------------------------------------------------------------
module swmq_mem (
    input  logic                i_clk,
    input  swmq_pkg::t_mem_req  i_req,
    output swmq_pkg::t_value    o_rdata
);

    swmq_pkg::t_value r_mem [0:swmq_pkg::DEPTH-1];
    swmq_pkg::t_value r_rdata;

    // Write on request, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/square_window_max_query.sv
// Sequence: a write transaction goes to the memory when it is accepted; an accepted query
// runs 4 reads of the single memory port, a drain state and a result state; an out-of-range
// query goes straight to the result state, which waits while the output holds an unaccepted result.
// One item is taken at a time. A build does 4 reads, a drain and a write per table entry, over all levels.
// Reset: control state clears and matrix_size returns to 512; the table is not cleared.
// ----------------------------------------------------------------------------
// square_window_max_query
// Two-dimensional sparse table for square window maximum queries, run by a
// small sequencer around one memory port and one shared max compare.
// ----------------------------------------------------------------------------
module square_window_max_query (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: matrix_size
    input  logic                          i_cfg_we,
    input  logic [swmq_pkg::SIZE_W-1:0]   i_cfg_wdata,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: row[8:0], col[17:9], side[27:18], value[59:28], zero[63:60]
    input  logic [swmq_pkg::IN_W-1:0]     s_axis_tdata,
    // tuser: command[1:0]
    input  logic [swmq_pkg::CMD_W-1:0]    s_axis_tuser,
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: max_value[31:0]
    output logic [swmq_pkg::OUT_W-1:0]    m_axis_tdata,
    // tuser: status[1:0]
    output logic [swmq_pkg::STATUS_W-1:0] m_axis_tuser
);

    localparam int DW = swmq_pkg::DIM_W;
    localparam int SW = swmq_pkg::SIZE_W;

    // Input field unpacking
    logic [DW-1:0]                  w_row;
    logic [DW-1:0]                  w_col;
    logic [swmq_pkg::SIDE_W-1:0]    w_side;
    swmq_pkg::t_value               w_value;
    logic                           w_accept;

    assign w_row    = s_axis_tdata[DW-1:0];
    assign w_col    = s_axis_tdata[2*DW-1:DW];
    assign w_side   = s_axis_tdata[2*DW+swmq_pkg::SIDE_W-1:2*DW];
    assign w_value  = s_axis_tdata[2*DW+swmq_pkg::SIDE_W+swmq_pkg::VALUE_WIDTH-1:
                                   2*DW+swmq_pkg::SIDE_W];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Registers
    swmq_pkg::t_state               r_state, n_state;
    logic [SW-1:0]                  r_size;
    logic                           r_build, n_build;
    logic [swmq_pkg::LEV_W-1:0]     r_rlev, n_rlev;
    logic [DW-1:0]                  r_row, n_row;
    logic [DW-1:0]                  r_col, n_col;
    logic [DW-1:0]                  r_off, n_off;
    logic [1:0]                     r_k, n_k;
    logic [swmq_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                           r_pend;
    logic                           r_first;
    swmq_pkg::t_value               r_acc;
    logic                           r_out_vld;
    swmq_pkg::t_value               r_out_max;
    logic [swmq_pkg::STATUS_W-1:0]  r_out_status;

    // Memory port
    swmq_pkg::t_mem_req             w_req;
    swmq_pkg::t_value               w_rdata;

    swmq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // Effective matrix size and level window
    logic [SW-1:0]                  w_n;
    logic [SW:0]                    w_win;
    logic [swmq_pkg::LEV_W:0]       w_wlev;
    logic                           w_lev_ok;
    logic [SW:0]                    w_col_end;
    logic [SW:0]                    w_row_end;

    assign w_n      = (r_size > SW'(swmq_pkg::MAX_DIM)) ? SW'(swmq_pkg::MAX_DIM) : r_size;
    assign w_wlev   = (swmq_pkg::LEV_W + 1)'(r_rlev) + 1'b1;
    assign w_win    = (SW + 1)'(1) << w_wlev;
    assign w_lev_ok = (w_wlev < (swmq_pkg::LEV_W + 1)'(swmq_pkg::LEVELS)) &&
                      (w_win <= (SW + 1)'(w_n));
    assign w_col_end = (SW + 1)'(r_col) + (SW + 1)'(1) + w_win;
    assign w_row_end = (SW + 1)'(r_row) + (SW + 1)'(1) + w_win;

    // Query range check and level choice
    logic [SW:0]                    w_q_rend;
    logic [SW:0]                    w_q_cend;
    logic [swmq_pkg::LOG_W-1:0]     w_q_lev;
    logic [swmq_pkg::SIDE_W-1:0]    w_q_k;
    logic [swmq_pkg::SIDE_W-1:0]    w_q_off;
    logic                           w_q_bad;

    assign w_q_rend = (SW + 1)'(w_row) + (SW + 1)'(w_side);
    assign w_q_cend = (SW + 1)'(w_col) + (SW + 1)'(w_side);
    assign w_q_lev  = swmq_pkg::f_log2(w_side);
    assign w_q_k    = swmq_pkg::SIDE_W'(1) << w_q_lev;
    assign w_q_off  = w_side - w_q_k;
    assign w_q_bad  = (w_side == '0) ||
                      (w_q_rend > (SW + 1)'(w_n)) ||
                      (w_q_cend > (SW + 1)'(w_n)) ||
                      (w_q_lev >= swmq_pkg::LOG_W'(swmq_pkg::LEVELS));

    // Result load condition
    logic w_out_free;
    assign w_out_free = !r_out_vld || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swmq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == swmq_pkg::CMD_BUILD) begin
                        n_state = swmq_pkg::ST_LEVEL;
                    end else if (s_axis_tuser == swmq_pkg::CMD_QUERY) begin
                        n_state = w_q_bad ? swmq_pkg::ST_DONE : swmq_pkg::ST_READ;
                    end
                end
            end
            swmq_pkg::ST_LEVEL: begin
                n_state = w_lev_ok ? swmq_pkg::ST_READ : swmq_pkg::ST_DONE;
            end
            swmq_pkg::ST_READ: begin
                if (r_k == 2'd3) begin
                    n_state = swmq_pkg::ST_DRAIN;
                end
            end
            swmq_pkg::ST_DRAIN: begin
                n_state = r_build ? swmq_pkg::ST_WRITE : swmq_pkg::ST_DONE;
            end
            swmq_pkg::ST_WRITE: begin
                if (w_col_end <= (SW + 1)'(w_n) || w_row_end <= (SW + 1)'(w_n)) begin
                    n_state = swmq_pkg::ST_READ;
                end else begin
                    n_state = swmq_pkg::ST_LEVEL;
                end
            end
            swmq_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = swmq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swmq_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer datapath
    always_comb begin
        n_build  = r_build;
        n_rlev   = r_rlev;
        n_row    = r_row;
        n_col    = r_col;
        n_off    = r_off;
        n_k      = r_k;
        n_status = r_status;
        case (r_state)
            swmq_pkg::ST_IDLE: begin
                n_k = '0;
                if (w_accept && s_axis_tuser == swmq_pkg::CMD_BUILD) begin
                    n_build  = 1'b1;
                    n_rlev   = '0;
                    n_status = swmq_pkg::STS_BUILT;
                end else if (w_accept && s_axis_tuser == swmq_pkg::CMD_QUERY) begin
                    n_build  = 1'b0;
                    n_rlev   = swmq_pkg::LEV_W'(w_q_lev);
                    n_row    = w_row;
                    n_col    = w_col;
                    n_off    = DW'(w_q_off);
                    n_status = w_q_bad ? swmq_pkg::STS_RANGE : swmq_pkg::STS_ANSWER;
                end
            end
            swmq_pkg::ST_LEVEL: begin
                n_row = '0;
                n_col = '0;
                n_k   = '0;
                n_off = DW'(1) << r_rlev;
            end
            swmq_pkg::ST_READ: begin
                n_k = r_k + 2'd1;
            end
            swmq_pkg::ST_WRITE: begin
                // Advance column, then row, then level
                n_k = '0;
                if (w_col_end <= (SW + 1)'(w_n)) begin
                    n_col = r_col + DW'(1);
                end else if (w_row_end <= (SW + 1)'(w_n)) begin
                    n_col = '0;
                    n_row = r_row + DW'(1);
                end else begin
                    n_rlev = r_rlev + swmq_pkg::LEV_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Memory requests
    always_comb begin
        w_req.we    = 1'b0;
        w_req.addr  = {r_rlev, r_row + (r_k[0] ? r_off : DW'(0)),
                       r_col + (r_k[1] ? r_off : DW'(0))};
        w_req.wdata = r_acc;
        case (r_state)
            swmq_pkg::ST_IDLE: begin
                w_req.we    = w_accept && (s_axis_tuser == swmq_pkg::CMD_WRITE);
                w_req.addr  = {swmq_pkg::LEV_W'(0), w_row, w_col};
                w_req.wdata = w_value;
            end
            swmq_pkg::ST_WRITE: begin
                w_req.we   = 1'b1;
                w_req.addr = {r_rlev + swmq_pkg::LEV_W'(1), r_row, r_col};
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swmq_pkg::ST_IDLE;
            r_size    <= SW'(swmq_pkg::MAX_DIM);
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_pend <= (r_state == swmq_pkg::ST_READ);
            if (r_state == swmq_pkg::ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_build  <= n_build;
        r_rlev   <= n_rlev;
        r_row    <= n_row;
        r_col    <= n_col;
        r_off    <= n_off;
        r_k      <= n_k;
        r_status <= n_status;
        r_first  <= (r_state == swmq_pkg::ST_READ) && (r_k == 2'd0);
        // Shared max compare over returning read data
        if (r_pend) begin
            if (r_first || (w_rdata > r_acc)) begin
                r_acc <= w_rdata;
            end
        end
        // Load the result register
        if (r_state == swmq_pkg::ST_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_out_max    <= (r_status == swmq_pkg::STS_ANSWER) ? r_acc : '0;
        end
    end

    assign s_axis_tready = (r_state == swmq_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_max;
    assign m_axis_tuser  = r_out_status;

endmodule
